@@ design/ec2p_pkg.sv @@
// ----------------------------------------------------------------------------
// ec2p_pkg
// Types and constants shared by the 2D elastic collision pipeline.
// ----------------------------------------------------------------------------
package ec2p_pkg;

    // divider geometry: numerator 2*m*|D|*|d|, denominator (m1+m2)*|d|^2
    localparam int NUM_W   = 130;
    localparam int DEN_W   = 98;
    localparam int QUO_W   = 33;
    localparam int DIV_LAT = QUO_W + 1;

    typedef struct packed {
        logic signed [31:0] first_pos_x;
        logic signed [31:0] first_pos_y;
        logic signed [31:0] first_vel_x;
        logic signed [31:0] first_vel_y;
        logic        [31:0] first_mass;
        logic        [30:0] first_radius;
        logic signed [31:0] second_pos_x;
        logic signed [31:0] second_pos_y;
        logic signed [31:0] second_vel_x;
        logic signed [31:0] second_vel_y;
        logic        [31:0] second_mass;
        logic        [30:0] second_radius;
    } t_pair_in;

    typedef struct packed {
        logic signed [31:0] out_first_vel_x;
        logic signed [31:0] out_first_vel_y;
        logic signed [31:0] out_second_vel_x;
        logic signed [31:0] out_second_vel_y;
        logic               collided;
        logic               coincident;
        logic               saturated;
    } t_pair_out;

endpackage

@@ design/ec2p_chan_if.sv @@
// ----------------------------------------------------------------------------
// ec2p_chan_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface ec2p_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ design/ec2p_div.sv @@
// ----------------------------------------------------------------------------
// ec2p_div
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients that do not fit in QUO_W bits.
// ----------------------------------------------------------------------------
module ec2p_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [ec2p_pkg::NUM_W-1:0]    i_num,
    input  logic [ec2p_pkg::DEN_W-1:0]    i_den,
    output logic [ec2p_pkg::QUO_W-1:0]    o_quo,
    output logic                          o_ovf
);
    import ec2p_pkg::*;

    logic [DEN_W-1:0] r_rem [0:QUO_W];
    logic [QUO_W-1:0] r_low [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    logic             r_ovf [0:QUO_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {1'b0, i_num[NUM_W-1:QUO_W]};
            r_low[0] <= i_num[QUO_W-1:0];
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            // high part already >= den: quotient needs more than QUO_W bits
            r_ovf[0] <= ({1'b0, i_num[NUM_W-1:QUO_W]} >= i_den);
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
        logic [DEN_W:0] w_sh;
        logic [DEN_W:0] w_dif;
        logic           w_ge;

        assign w_sh  = {r_rem[k-1], r_low[k-1][QUO_W-1]};
        assign w_dif = w_sh - {1'b0, r_den[k-1]};
        assign w_ge  = (w_sh >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_dif[DEN_W-1:0] : w_sh[DEN_W-1:0];
                r_low[k] <= {r_low[k-1][QUO_W-2:0], 1'b0};
                r_den[k] <= r_den[k-1];
                r_quo[k] <= {r_quo[k-1][QUO_W-2:0], w_ge};
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = r_quo[QUO_W];
    assign o_ovf = r_ovf[QUO_W];

endmodule

@@ design/elastic_collision_2d_pair.sv @@
// ----------------------------------------------------------------------------
// elastic_collision_2d_pair
// Velocities of two circles after a 2D elastic collision, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   i_pair carries one particle pair per transfer (positions, velocities,
//   masses, radii); o_res returns the four new velocity components and the
//   collided / coincident / saturated flags, one result per pair, in order.
//   The pipeline has 7 stages of differences, squares and 16-bit sliced
//   products, 34 stages of the bit-per-stage quotient dividers and one
//   output register.
//   Throughput is one pair per cycle; a new pair is taken every cycle while
//   the output register is empty or being drained.
//   When the receiver holds ready low with a result waiting, the whole
//   pipeline freezes and i_pair.ready drops; nothing is lost or repeated.
//   Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module elastic_collision_2d_pair (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ec2p_chan_if.sink   i_pair,
    ec2p_chan_if.source o_res
);
    import ec2p_pkg::*;

    typedef struct packed {
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic signed [31:0] v2x;
        logic signed [31:0] v2y;
    } t_vel;

    typedef struct packed {
        t_vel        vel;
        logic [31:0] dxm;
        logic [31:0] dym;
        logic        dxn;
        logic        dyn;
        logic [31:0] dvxm;
        logic [31:0] dvym;
        logic        dvxn;
        logic        dvyn;
        logic [31:0] rs;
        logic [32:0] ms;
        logic [31:0] m1;
        logic [31:0] m2;
        logic        coin;
    } t_s1;

    typedef struct packed {
        t_vel        vel;
        logic [31:0] dxm;
        logic [31:0] dym;
        logic        dxn;
        logic        dyn;
        logic [32:0] ms;
        logic [31:0] m1;
        logic [31:0] m2;
        logic        coin;
        logic [63:0] sx;
        logic [63:0] sy;
        logic [63:0] lim;
        logic [63:0] a;
        logic [63:0] b;
        logic        an;
        logic        bn;
    } t_s2;

    typedef struct packed {
        t_vel        vel;
        logic [31:0] dxm;
        logic [31:0] dym;
        logic        sxn;
        logic        syn;
        logic [32:0] ms;
        logic [31:0] m1;
        logic [31:0] m2;
        logic        coin;
        logic        coll;
        logic        apply;
        logic [64:0] s;
        logic [64:0] dm;
    } t_s3;

    typedef struct packed {
        t_vel        vel;
        logic        sxn;
        logic        syn;
        logic        coin;
        logic        coll;
        logic        apply;
        logic [31:0] m1;
        logic [31:0] m2;
        logic [64:0] dm;
        logic [15:0] dxh;
        logic [15:0] dyh;
        logic [80:0] px_lo;
        logic [80:0] py_lo;
        logic [64:0] s;
        logic [15:0] ms_hi;
        logic [81:0] den_lo;
    } t_s4;

    typedef struct packed {
        t_vel        vel;
        logic        sxn;
        logic        syn;
        logic        coin;
        logic        coll;
        logic        apply;
        logic [31:0] m1;
        logic [31:0] m2;
        logic [96:0] px;
        logic [96:0] py;
        logic [97:0] den;
    } t_s5;

    typedef struct packed {
        t_vel         vel;
        logic         sxn;
        logic         syn;
        logic         coin;
        logic         coll;
        logic         apply;
        logic [15:0]  m1h;
        logic [15:0]  m2h;
        logic [96:0]  px;
        logic [96:0]  py;
        logic [97:0]  den;
        logic [112:0] n1x_lo;
        logic [112:0] n1y_lo;
        logic [112:0] n2x_lo;
        logic [112:0] n2y_lo;
    } t_s6;

    typedef struct packed {
        t_vel         vel;
        logic         sxn;
        logic         syn;
        logic         coin;
        logic         coll;
        logic         apply;
    } t_side;

    typedef struct packed {
        t_side        sd;
        logic [97:0]  den;
        logic [128:0] n1x;
        logic [128:0] n1y;
        logic [128:0] n2x;
        logic [128:0] n2y;
    } t_s7;

    function automatic logic [31:0] f_mag(input logic [32:0] v);
        logic [32:0] t;
        t = v[32] ? (33'd0 - v) : v;
        return t[31:0];
    endfunction

    // {saturated, value} of v +/- q, q forced large on overflow, 0 when apply is low
    function automatic logic [32:0] f_upd(
        input logic [31:0] v,
        input logic [32:0] q,
        input logic        ovf,
        input logic        add,
        input logic        apply
    );
        logic [33:0] qe;
        logic [35:0] ve;
        logic [35:0] s;
        qe = !apply ? 34'd0 : (ovf ? {1'b1, 33'd0} : {1'b0, q});
        ve = {{4{v[31]}}, v};
        s  = add ? (ve + {2'b00, qe}) : (ve - {2'b00, qe});
        if (s[35:31] == 5'b00000 || s[35:31] == 5'b11111) begin
            return {1'b0, s[31:0]};
        end else if (s[35]) begin
            return {1'b1, 32'h8000_0000};
        end else begin
            return {1'b1, 32'h7fff_ffff};
        end
    endfunction

    logic w_en;

    logic [7:1]       r_vld;
    logic             r_dvld [0:DIV_LAT-1];
    logic             r_out_vld;

    t_s1       r_s1, n_s1;
    t_s2       r_s2, n_s2;
    t_s3       r_s3, n_s3;
    t_s4       r_s4, n_s4;
    t_s5       r_s5, n_s5;
    t_s6       r_s6, n_s6;
    t_s7       r_s7, n_s7;
    t_side     r_side [0:DIV_LAT-1];
    t_pair_out r_out, n_out;

    logic [QUO_W-1:0] w_q1x, w_q1y, w_q2x, w_q2y;
    logic             w_o1x, w_o1y, w_o2x, w_o2y;

    assign w_en         = !r_out_vld || o_res.ready;
    assign i_pair.ready = w_en;
    assign o_res.valid  = r_out_vld;
    assign o_res.payload = r_out;

    // stage 1: differences and sums
    always_comb begin
        logic [32:0] dx, dy, dvx, dvy;
        t_pair_in    p;
        p   = i_pair.payload;
        dx  = {p.first_pos_x[31], p.first_pos_x} - {p.second_pos_x[31], p.second_pos_x};
        dy  = {p.first_pos_y[31], p.first_pos_y} - {p.second_pos_y[31], p.second_pos_y};
        dvx = {p.first_vel_x[31], p.first_vel_x} - {p.second_vel_x[31], p.second_vel_x};
        dvy = {p.first_vel_y[31], p.first_vel_y} - {p.second_vel_y[31], p.second_vel_y};
        n_s1.vel.v1x = p.first_vel_x;
        n_s1.vel.v1y = p.first_vel_y;
        n_s1.vel.v2x = p.second_vel_x;
        n_s1.vel.v2y = p.second_vel_y;
        n_s1.dxm  = f_mag(dx);
        n_s1.dym  = f_mag(dy);
        n_s1.dxn  = dx[32];
        n_s1.dyn  = dy[32];
        n_s1.dvxm = f_mag(dvx);
        n_s1.dvym = f_mag(dvy);
        n_s1.dvxn = dvx[32];
        n_s1.dvyn = dvy[32];
        n_s1.rs   = {1'b0, p.first_radius} + {1'b0, p.second_radius};
        n_s1.ms   = {1'b0, p.first_mass} + {1'b0, p.second_mass};
        n_s1.m1   = p.first_mass;
        n_s1.m2   = p.second_mass;
        n_s1.coin = (dx == 33'd0) && (dy == 33'd0);
    end

    // stage 2: 32x32 products
    always_comb begin
        n_s2.vel  = r_s1.vel;
        n_s2.dxm  = r_s1.dxm;
        n_s2.dym  = r_s1.dym;
        n_s2.dxn  = r_s1.dxn;
        n_s2.dyn  = r_s1.dyn;
        n_s2.ms   = r_s1.ms;
        n_s2.m1   = r_s1.m1;
        n_s2.m2   = r_s1.m2;
        n_s2.coin = r_s1.coin;
        n_s2.sx   = 64'(r_s1.dxm) * 64'(r_s1.dxm);
        n_s2.sy   = 64'(r_s1.dym) * 64'(r_s1.dym);
        n_s2.lim  = 64'(r_s1.rs) * 64'(r_s1.rs);
        n_s2.a    = 64'(r_s1.dvxm) * 64'(r_s1.dxm);
        n_s2.b    = 64'(r_s1.dvym) * 64'(r_s1.dym);
        n_s2.an   = r_s1.dvxn ^ r_s1.dxn;
        n_s2.bn   = r_s1.dvyn ^ r_s1.dyn;
    end

    // stage 3: distance test and signed dot product
    always_comb begin
        logic dneg;
        n_s3.vel  = r_s2.vel;
        n_s3.dxm  = r_s2.dxm;
        n_s3.dym  = r_s2.dym;
        n_s3.ms   = r_s2.ms;
        n_s3.m1   = r_s2.m1;
        n_s3.m2   = r_s2.m2;
        n_s3.coin = r_s2.coin;
        n_s3.s    = 65'(r_s2.sx) + 65'(r_s2.sy);
        n_s3.coll = !r_s2.coin && (n_s3.s <= 65'(r_s2.lim));
        n_s3.apply = n_s3.coll && (r_s2.ms != 33'd0);
        if (r_s2.an == r_s2.bn) begin
            n_s3.dm = 65'(r_s2.a) + 65'(r_s2.b);
            dneg    = r_s2.an;
        end else if (r_s2.a >= r_s2.b) begin
            n_s3.dm = 65'(r_s2.a - r_s2.b);
            dneg    = r_s2.an;
        end else begin
            n_s3.dm = 65'(r_s2.b - r_s2.a);
            dneg    = r_s2.bn;
        end
        n_s3.sxn = dneg ^ r_s2.dxn;
        n_s3.syn = dneg ^ r_s2.dyn;
    end

    // stage 4: low slices of D*|d| and M*S
    always_comb begin
        n_s4.vel    = r_s3.vel;
        n_s4.sxn    = r_s3.sxn;
        n_s4.syn    = r_s3.syn;
        n_s4.coin   = r_s3.coin;
        n_s4.coll   = r_s3.coll;
        n_s4.apply  = r_s3.apply;
        n_s4.m1     = r_s3.m1;
        n_s4.m2     = r_s3.m2;
        n_s4.dm     = r_s3.dm;
        n_s4.dxh    = r_s3.dxm[31:16];
        n_s4.dyh    = r_s3.dym[31:16];
        n_s4.px_lo  = 81'(r_s3.dm) * 81'(r_s3.dxm[15:0]);
        n_s4.py_lo  = 81'(r_s3.dm) * 81'(r_s3.dym[15:0]);
        n_s4.s      = r_s3.s;
        n_s4.ms_hi  = r_s3.ms[32:17];
        n_s4.den_lo = 82'(r_s3.s) * 82'(r_s3.ms[16:0]);
    end

    // stage 5: high slices
    always_comb begin
        logic [80:0] pxh, pyh, dh;
        pxh = 81'(r_s4.dm) * 81'(r_s4.dxh);
        pyh = 81'(r_s4.dm) * 81'(r_s4.dyh);
        dh  = 81'(r_s4.s) * 81'(r_s4.ms_hi);
        n_s5.vel   = r_s4.vel;
        n_s5.sxn   = r_s4.sxn;
        n_s5.syn   = r_s4.syn;
        n_s5.coin  = r_s4.coin;
        n_s5.coll  = r_s4.coll;
        n_s5.apply = r_s4.apply;
        n_s5.m1    = r_s4.m1;
        n_s5.m2    = r_s4.m2;
        n_s5.px    = 97'(r_s4.px_lo) + {pxh, 16'd0};
        n_s5.py    = 97'(r_s4.py_lo) + {pyh, 16'd0};
        n_s5.den   = 98'(r_s4.den_lo) + {dh, 17'd0};
    end

    // stage 6: mass products, low slices
    always_comb begin
        n_s6.vel    = r_s5.vel;
        n_s6.sxn    = r_s5.sxn;
        n_s6.syn    = r_s5.syn;
        n_s6.coin   = r_s5.coin;
        n_s6.coll   = r_s5.coll;
        n_s6.apply  = r_s5.apply;
        n_s6.m1h    = r_s5.m1[31:16];
        n_s6.m2h    = r_s5.m2[31:16];
        n_s6.px     = r_s5.px;
        n_s6.py     = r_s5.py;
        n_s6.den    = r_s5.den;
        n_s6.n1x_lo = 113'(r_s5.px) * 113'(r_s5.m2[15:0]);
        n_s6.n1y_lo = 113'(r_s5.py) * 113'(r_s5.m2[15:0]);
        n_s6.n2x_lo = 113'(r_s5.px) * 113'(r_s5.m1[15:0]);
        n_s6.n2y_lo = 113'(r_s5.py) * 113'(r_s5.m1[15:0]);
    end

    // stage 7: mass products, high slices
    always_comb begin
        logic [112:0] h1x, h1y, h2x, h2y;
        h1x = 113'(r_s6.px) * 113'(r_s6.m2h);
        h1y = 113'(r_s6.py) * 113'(r_s6.m2h);
        h2x = 113'(r_s6.px) * 113'(r_s6.m1h);
        h2y = 113'(r_s6.py) * 113'(r_s6.m1h);
        n_s7.sd.vel   = r_s6.vel;
        n_s7.sd.sxn   = r_s6.sxn;
        n_s7.sd.syn   = r_s6.syn;
        n_s7.sd.coin  = r_s6.coin;
        n_s7.sd.coll  = r_s6.coll;
        n_s7.sd.apply = r_s6.apply;
        n_s7.den      = r_s6.den;
        n_s7.n1x      = 129'(r_s6.n1x_lo) + {h1x, 16'd0};
        n_s7.n1y      = 129'(r_s6.n1y_lo) + {h1y, 16'd0};
        n_s7.n2x      = 129'(r_s6.n2x_lo) + {h2x, 16'd0};
        n_s7.n2y      = 129'(r_s6.n2y_lo) + {h2y, 16'd0};
    end

    // numerator carries the factor 2 as a left shift
    ec2p_div u_div_1x (.i_clk(i_clk), .i_en(w_en), .i_num({r_s7.n1x, 1'b0}),
                       .i_den(r_s7.den), .o_quo(w_q1x), .o_ovf(w_o1x));
    ec2p_div u_div_1y (.i_clk(i_clk), .i_en(w_en), .i_num({r_s7.n1y, 1'b0}),
                       .i_den(r_s7.den), .o_quo(w_q1y), .o_ovf(w_o1y));
    ec2p_div u_div_2x (.i_clk(i_clk), .i_en(w_en), .i_num({r_s7.n2x, 1'b0}),
                       .i_den(r_s7.den), .o_quo(w_q2x), .o_ovf(w_o2x));
    ec2p_div u_div_2y (.i_clk(i_clk), .i_en(w_en), .i_num({r_s7.n2y, 1'b0}),
                       .i_den(r_s7.den), .o_quo(w_q2y), .o_ovf(w_o2y));

    // output: apply the deltas and saturate
    always_comb begin
        t_side       sd;
        logic [32:0] u1x, u1y, u2x, u2y;
        sd  = r_side[DIV_LAT-1];
        u1x = f_upd(sd.vel.v1x, w_q1x, w_o1x,  sd.sxn, sd.apply);
        u1y = f_upd(sd.vel.v1y, w_q1y, w_o1y,  sd.syn, sd.apply);
        u2x = f_upd(sd.vel.v2x, w_q2x, w_o2x, !sd.sxn, sd.apply);
        u2y = f_upd(sd.vel.v2y, w_q2y, w_o2y, !sd.syn, sd.apply);
        n_out.out_first_vel_x  = u1x[31:0];
        n_out.out_first_vel_y  = u1y[31:0];
        n_out.out_second_vel_x = u2x[31:0];
        n_out.out_second_vel_y = u2y[31:0];
        n_out.collided         = sd.coll;
        n_out.coincident       = sd.coin;
        n_out.saturated        = u1x[32] | u1y[32] | u2x[32] | u2y[32];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1      <= n_s1;
            r_s2      <= n_s2;
            r_s3      <= n_s3;
            r_s4      <= n_s4;
            r_s5      <= n_s5;
            r_s6      <= n_s6;
            r_s7      <= n_s7;
            r_side[0] <= r_s7.sd;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_out     <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r_dvld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld     <= {r_vld[6:1], i_pair.valid};
            r_dvld[0] <= r_vld[7];
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dvld[k] <= r_dvld[k-1];
            end
            r_out_vld <= r_dvld[DIV_LAT-1];
        end
    end

endmodule
